// ===== rtl/bmhq_pkg.sv =====
`default_nettype none

package bmhq_pkg;

   // Heap geometry
   localparam int CAPACITY = 1024;
   localparam int KEY_W    = 32;
   localparam int TAG_W    = 16;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Request kinds
   localparam logic FN_INSERT = 1'b0;
   localparam logic FN_POP    = 1'b1;

   // Response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [KEY_W-1:0] key;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/bmhq_store.sv =====
`default_nettype none

module bmhq_store
   import bmhq_pkg::*;
(
   input  wire logic        clock,
   input  wire mem_ctl_type ctl,
   input  wire entry_type   wr_data,
   output entry_type        rd_data
);

   entry_type mem [CAPACITY];
   entry_type rd_data_ff;

   // One write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/bmhq_cmp.sv =====
`default_nettype none

module bmhq_cmp
   import bmhq_pkg::*;
(
   input  wire logic             max_first,
   input  wire logic [KEY_W-1:0] key_a,
   input  wire logic [KEY_W-1:0] key_b,
   output logic                  a_first
);

   // Strict ordering: equal keys never order first
   always_comb begin
      if (max_first) begin
         a_first = key_a > key_b;
      end else begin
         a_first = key_a < key_b;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/binary_min_heap_queue.sv =====
// Channel | Dir | Handshake               | Payload
// req     | in  | req_tvalid/req_tready   | tdata: item_key, item_tag; tuser: func
// rsp     | out | rsp_tvalid/rsp_tready   | tdata: out_key, out_tag, count_after; tuser: status
// csr     | in  | csr_tvalid/csr_tready   | tdata bit 0: max_first
//
// One request at a time through a shared compare unit and a one-write, one-read heap memory.
// Insert climbs from the new slot, comparing the entry with one parent per level. Pop reads
// the root, then the last entry unless the heap is now empty, and sifts that entry down: it
// reads the left child, then the right if present, and compares the one that orders first.
// Synchronous active-high reset empties the heap and selects min-first; memory is not cleared.
// A response waits in an output register while the next request runs; a later one holds
// until that register frees up.

`default_nettype none

module binary_min_heap_queue
   import bmhq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // [31:0] item_key, [47:32] item_tag
   input  wire logic [0:0]  req_tuser,   // [0] func

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [31:0] out_key, [47:32] out_tag,
                                         // [58:48] count_after, rest zero
   output logic [1:0]       rsp_tuser,   // [1:0] status

   input  wire logic        csr_tvalid,
   output logic             csr_tready,
   input  wire logic [7:0]  csr_tdata    // [0] max_first, rest unused
);

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE     = 4'd0;
   localparam logic [ST_W-1:0] S_UP_RD    = 4'd1;
   localparam logic [ST_W-1:0] S_UP_CMP   = 4'd2;
   localparam logic [ST_W-1:0] S_POP_ROOT = 4'd3;
   localparam logic [ST_W-1:0] S_POP_LAST = 4'd4;
   localparam logic [ST_W-1:0] S_POP_LOAD = 4'd5;
   localparam logic [ST_W-1:0] S_DN_RDA   = 4'd6;
   localparam logic [ST_W-1:0] S_DN_RDB   = 4'd7;
   localparam logic [ST_W-1:0] S_DN_SEL   = 4'd8;
   localparam logic [ST_W-1:0] S_DN_CMP   = 4'd9;
   localparam logic [ST_W-1:0] S_FIN      = 4'd10;

   localparam int IDX2_W = ADDR_W + 2;

   logic [ST_W-1:0]   state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              max_first_ff;
   entry_type         cur_ff, cur_in;
   entry_type         child_ff, child_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] cidx_ff, cidx_in;
   logic [KEY_W-1:0]  res_key_ff, res_key_in;
   logic [TAG_W-1:0]  res_tag_ff, res_tag_in;
   logic [1:0]        res_status_ff, res_status_in;

   logic              rsp_valid_ff;
   logic [KEY_W-1:0]  rsp_key_ff;
   logic [TAG_W-1:0]  rsp_tag_ff;
   logic [1:0]        rsp_status_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   mem_ctl_type       mem_ctl;
   entry_type         mem_wdata;
   entry_type         mem_rdata;

   logic [KEY_W-1:0]  cmp_a;
   logic [KEY_W-1:0]  cmp_b;
   logic              a_first;

   logic [ADDR_W-1:0] parent_idx;
   logic [IDX2_W-1:0] child_a_w;
   logic [IDX2_W-1:0] child_b_w;
   logic              has_a;
   logic              has_b;
   logic              req_fire;
   logic              rsp_load;
   entry_type         req_entry;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_tready = 1'b1;

   assign req_entry.key = req_tdata[KEY_W-1:0];
   assign req_entry.tag = req_tdata[KEY_W+TAG_W-1:KEY_W];

   // Heap index arithmetic
   assign parent_idx = (idx_ff - ADDR_W'(1)) >> 1;
   assign child_a_w  = IDX2_W'({idx_ff, 1'b1});
   assign child_b_w  = child_a_w + IDX2_W'(1);
   assign has_a      = child_a_w < IDX2_W'(count_ff);
   assign has_b      = child_b_w < IDX2_W'(count_ff);

   bmhq_store u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   // Route the shared comparator by step
   always_comb begin
      cmp_a = cur_ff.key;
      cmp_b = mem_rdata.key;
      case (state_ff)
         S_DN_SEL: begin
            cmp_a = child_ff.key;
            cmp_b = mem_rdata.key;
         end
         S_DN_CMP: begin
            cmp_a = child_ff.key;
            cmp_b = cur_ff.key;
         end
         default: begin
            cmp_a = cur_ff.key;
            cmp_b = mem_rdata.key;
         end
      endcase
   end

   bmhq_cmp u_cmp (
      .max_first (max_first_ff),
      .key_a     (cmp_a),
      .key_b     (cmp_b),
      .a_first   (a_first)
   );

   assign rsp_load = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_tready);

   // Sequencer: the moving entry stays in cur_ff and lands once, at its final slot
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      child_in      = child_ff;
      idx_in        = idx_ff;
      cidx_in       = cidx_ff;
      res_key_in    = res_key_ff;
      res_tag_in    = res_tag_ff;
      res_status_in = res_status_ff;
      mem_ctl       = '0;
      mem_wdata     = cur_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_key_in    = '0;
               res_tag_in    = '0;
               res_status_in = ST_OK;
               if (req_tuser[0] == FN_INSERT) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     res_status_in = ST_FULL;
                     state_in      = S_FIN;
                  end else begin
                     cur_in   = req_entry;
                     idx_in   = count_ff[ADDR_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                     state_in      = S_FIN;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                     state_in = S_POP_ROOT;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (idx_ff == '0) begin
               // Reached the root: drop the entry here
               mem_ctl.wr_en   = 1'b1;
               mem_ctl.wr_addr = idx_ff;
               state_in        = S_FIN;
            end else begin
               mem_ctl.rd_en   = 1'b1;
               mem_ctl.rd_addr = parent_idx;
               state_in        = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = idx_ff;
            if (a_first) begin
               // Move parent down, climb one level
               mem_wdata = mem_rdata;
               idx_in    = parent_idx;
               state_in  = S_UP_RD;
            end else begin
               state_in  = S_FIN;
            end
         end
         S_POP_ROOT: begin
            mem_ctl.rd_en   = 1'b1;
            mem_ctl.rd_addr = '0;
            state_in        = S_POP_LAST;
         end
         S_POP_LAST: begin
            res_key_in = mem_rdata.key;
            res_tag_in = mem_rdata.tag;
            if (count_ff == '0) begin
               state_in = S_FIN;
            end else begin
               mem_ctl.rd_en   = 1'b1;
               mem_ctl.rd_addr = count_ff[ADDR_W-1:0];
               state_in        = S_POP_LOAD;
            end
         end
         S_POP_LOAD: begin
            cur_in   = mem_rdata;
            idx_in   = '0;
            state_in = S_DN_RDA;
         end
         S_DN_RDA: begin
            if (has_a) begin
               mem_ctl.rd_en   = 1'b1;
               mem_ctl.rd_addr = child_a_w[ADDR_W-1:0];
               state_in        = S_DN_RDB;
            end else begin
               mem_ctl.wr_en   = 1'b1;
               mem_ctl.wr_addr = idx_ff;
               state_in        = S_FIN;
            end
         end
         S_DN_RDB: begin
            child_in = mem_rdata;
            cidx_in  = child_a_w[ADDR_W-1:0];
            if (has_b) begin
               mem_ctl.rd_en   = 1'b1;
               mem_ctl.rd_addr = child_b_w[ADDR_W-1:0];
               state_in        = S_DN_SEL;
            end else begin
               state_in        = S_DN_CMP;
            end
         end
         S_DN_SEL: begin
            // Take the right child unless the left orders strictly first
            if (!a_first) begin
               child_in = mem_rdata;
               cidx_in  = child_b_w[ADDR_W-1:0];
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = idx_ff;
            if (a_first) begin
               mem_wdata = child_ff;
               idx_in    = cidx_ff;
               state_in  = S_DN_RDA;
            end else begin
               state_in  = S_FIN;
            end
         end
         S_FIN: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         max_first_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_tvalid && csr_tready) begin
            max_first_ff <= csr_tdata[0];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      child_ff      <= child_in;
      idx_ff        <= idx_in;
      cidx_ff       <= cidx_in;
      res_key_ff    <= res_key_in;
      res_tag_ff    <= res_tag_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_key_ff    <= res_key_ff;
         rsp_tag_ff    <= res_tag_ff;
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_count_ff, rsp_tag_ff, rsp_key_ff};
   assign rsp_tuser  = rsp_status_ff;

   // Fill count never exceeds the heap depth
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   // Every heap write lands inside the occupied region
   a_write_inside : assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |-> (CNT_W'(mem_ctl.wr_addr) < count_ff))
      else $error("heap write outside occupied entries");

   // An empty-pop response reports an empty heap
   a_empty_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_EMPTY) |-> (rsp_count_ff == '0))
      else $error("empty status with nonzero count");

   // A rejected insert leaves the fill count unchanged
   a_full_hold : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser[0] == FN_INSERT && count_ff == CNT_W'(CAPACITY))
      |=> (count_ff == CNT_W'(CAPACITY)))
      else $error("full insert changed the count");

endmodule

`default_nettype wire
